FILE: src/sapq_pkg.sv
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and codes for the sorted-array priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

   localparam int unsigned CAPACITY_DEF = 128;
   localparam int unsigned VALUE_W      = 32;
   localparam int unsigned FILL_W       = 8;

   localparam logic [1:0] FUNC_ENQ  = 2'd0;
   localparam logic [1:0] FUNC_DEQ  = 2'd1;
   localparam logic [1:0] FUNC_PEEK = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]                 func;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  result_value;
      logic [1:0]                 status;
      logic [FILL_W-1:0]          fill_count;
   } rsp_type;

   // Broadcast to every cell of the chain
   typedef struct packed {
      logic                       enq;
      logic                       deq;
      logic signed [VALUE_W-1:0]  value;
   } cell_ctrl_type;

endpackage

FILE: src/sapq_cell.sv
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted chain: holds one entry, shifts right on insert
// behind a smaller new value, shifts left on removal of the head.
// ----------------------------------------------------------------------------
module sapq_cell #(
   parameter int unsigned IDX = 0,
   parameter int unsigned CW  = 8
) (
   input  logic                                clock,
   input  sapq_pkg::cell_ctrl_type             ctrl,
   input  logic [CW-1:0]                       count,
   input  logic                                left_take,
   input  logic signed [sapq_pkg::VALUE_W-1:0] left_data,
   input  logic signed [sapq_pkg::VALUE_W-1:0] right_data,
   output logic                                take,
   output logic signed [sapq_pkg::VALUE_W-1:0] data
);

   logic signed [sapq_pkg::VALUE_W-1:0] entry_ff;
   logic signed [sapq_pkg::VALUE_W-1:0] entry_in;
   logic                                live;

   assign live = count > CW'(IDX);
   // new value belongs at or before this slot
   assign take = !live || (ctrl.value < entry_ff);
   assign data = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.enq && take) begin
         entry_in = left_take ? left_data : ctrl.value;
      end else if (ctrl.deq) begin
         entry_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: src/sorted_array_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Min-first priority queue kept sorted in a chain of CAPACITY cells.
// The result is registered in the cycle after the transaction is accepted.
// Throughput: one operation per cycle while the response is not stalled;
// every cell compares against the broadcast value and shifts in the same cycle.
// Reset clears the fill count and the output valid; entry contents are
// not cleared (slots past the count are never read).
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core #(
   parameter int unsigned CAPACITY = sapq_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sapq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sapq_pkg::rsp_type rsp_data
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   sapq_pkg::rsp_type                   rsp_data_ff;
   sapq_pkg::rsp_type                   rsp_data_in;
   logic [CW-1:0]                       count_ff;
   logic [CW-1:0]                       count_in;
   logic                                accept;
   logic                                full;
   logic                                empty;
   sapq_pkg::cell_ctrl_type             ctrl;
   logic                                take [CAPACITY];
   logic signed [sapq_pkg::VALUE_W-1:0] data [CAPACITY];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CW'(CAPACITY);
   assign empty     = count_ff == '0;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ctrl.enq   = accept && (req_data.func == sapq_pkg::FUNC_ENQ) && !full;
   assign ctrl.deq   = accept && (req_data.func == sapq_pkg::FUNC_DEQ) && !empty;
   assign ctrl.value = req_data.value;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                                lt_in;
      logic signed [sapq_pkg::VALUE_W-1:0] ld_in;
      logic signed [sapq_pkg::VALUE_W-1:0] rd_in;

      if (i == 0) begin : g_first
         assign lt_in = 1'b0;
         assign ld_in = '0;
      end else begin : g_mid
         assign lt_in = take[i-1];
         assign ld_in = data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign rd_in = '0;
      end else begin : g_inner
         assign rd_in = data[i+1];
      end

      sapq_cell #(
         .IDX (i),
         .CW  (CW)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .left_take  (lt_in),
         .left_data  (ld_in),
         .right_data (rd_in),
         .take       (take[i]),
         .data       (data[i])
      );
   end

   always_comb begin
      count_in    = count_ff;
      rsp_data_in = rsp_data_ff;
      if (ctrl.enq) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.deq) begin
         count_in = count_ff - CW'(1);
      end
      if (accept) begin
         rsp_data_in.result_value = '0;
         rsp_data_in.status       = sapq_pkg::ST_OK;
         unique case (req_data.func)
            sapq_pkg::FUNC_ENQ: begin
               if (full) begin
                  rsp_data_in.status = sapq_pkg::ST_FULL;
               end
            end
            sapq_pkg::FUNC_DEQ, sapq_pkg::FUNC_PEEK: begin
               if (empty) begin
                  rsp_data_in.status = sapq_pkg::ST_EMPTY;
               end else begin
                  rsp_data_in.result_value = data[0];
               end
            end
            default: begin
            end
         endcase
         rsp_data_in.fill_count = sapq_pkg::FILL_W'(count_in);
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
